FILE: sv/vnet_pkg.sv
// Shared definitions for the virtio network register file.
// Holds the command codes, the common-config offsets and the queue access word.
// No dependencies.
package vnet_pkg;

    // Bus access commands
    localparam logic [2:0] CMD_COMMON_READ  = 3'd0;
    localparam logic [2:0] CMD_COMMON_WRITE = 3'd1;
    localparam logic [2:0] CMD_DEVICE_READ  = 3'd2;
    localparam logic [2:0] CMD_ISR_READ     = 3'd3;
    localparam logic [2:0] CMD_RAISE_IRQ    = 3'd4;

    // Configuration register indexes
    localparam logic CFG_DMA_ENABLE = 1'b0;
    localparam logic CFG_MAC        = 1'b1;

    // Common-config offsets
    localparam logic [7:0] OFF_DEV_FEAT_SEL = 8'h00;
    localparam logic [7:0] OFF_DEV_FEAT     = 8'h04;
    localparam logic [7:0] OFF_DRV_FEAT_SEL = 8'h08;
    localparam logic [7:0] OFF_DRV_FEAT     = 8'h0C;
    localparam logic [7:0] OFF_MSIX_CFG     = 8'h10;
    localparam logic [7:0] OFF_NUM_QUEUES   = 8'h12;
    localparam logic [7:0] OFF_STATUS       = 8'h14;
    localparam logic [7:0] OFF_GENERATION   = 8'h15;
    localparam logic [7:0] OFF_Q_SELECT     = 8'h16;
    localparam logic [7:0] OFF_Q_SIZE       = 8'h18;
    localparam logic [7:0] OFF_Q_MSIX       = 8'h1A;
    localparam logic [7:0] OFF_Q_ENABLE     = 8'h1C;
    localparam logic [7:0] OFF_Q_NOTIFY     = 8'h1E;
    localparam logic [7:0] OFF_Q_DESC_LO    = 8'h20;
    localparam logic [7:0] OFF_Q_DESC_HI    = 8'h24;
    localparam logic [7:0] OFF_Q_AVAIL_LO   = 8'h28;
    localparam logic [7:0] OFF_Q_AVAIL_HI   = 8'h2C;
    localparam logic [7:0] OFF_Q_USED_LO    = 8'h30;
    localparam logic [7:0] OFF_Q_USED_HI    = 8'h34;
    localparam logic [7:0] CFG_REGION_BYTES = 8'h38;

    localparam logic [8:0] MAC_BYTES = 9'd6;

    localparam logic [31:0] MSIX_UNUSED    = 32'h0000_FFFF;
    localparam logic [31:0] DEV_FEAT_WIN0  = 32'h0000_0020;
    localparam logic [31:0] DEV_FEAT_WIN1  = 32'h0000_0001;
    localparam int          FEAT_VERSION_1 = 32;
    localparam int          STATUS_DRIVER_OK_BIT = 2;

    localparam logic [3:0] HDR_LEN_V1     = 4'd12;
    localparam logic [3:0] HDR_LEN_LEGACY = 4'd10;

    // Access presented to every queue lane.
    typedef struct packed {
        logic        wen;    // a sized, accepted common-config write
        logic        clear;  // status written with zero
        logic [7:0]  off;
        logic [31:0] data;
    } t_qacc;

endpackage

FILE: sv/virtio_net_pci_register_file_unit.sv
// Top level of the virtio network register file: input word register,
// result register and handshakes. Depends on vnet_pkg and vnet_core.
//
//   channel   direction  handshake                  payload
//   access    in         i_in_valid / o_in_stall    cmd, reg_offset, access_size,
//                                                   write_data, queue_index
//   result    out        o_out_valid / i_out_stall  read_data, access_error,
//                                                   queue_ready, header_length
//   config    in         i_cfg_we                   i_cfg_index, i_cfg_data
//
// An accepted word waits in the input register until it is decoded, and its
// result is registered as it is decoded. Without a stalled result, one word per
// cycle is sustained; the single decode stage sets that rate.
// Reset is synchronous and active low; both word registers come up empty.
// A stalled result holds the decode stage, which then stalls the input.
module virtio_net_pci_register_file_unit #(
    parameter int QUEUE_COUNT   = 2,
    parameter int MAX_RING_SIZE = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [2:0]  i_cmd,
    input  logic [7:0]  i_reg_offset,
    input  logic [2:0]  i_access_size,
    input  logic [31:0] i_write_data,
    input  logic [3:0]  i_queue_index,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [31:0] o_read_data,
    output logic        o_access_error,
    output logic        o_queue_ready,
    output logic [3:0]  o_header_length,
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [47:0] i_cfg_data
);
    import vnet_pkg::*;

    logic        r_in_valid;
    logic [2:0]  r_cmd;
    logic [7:0]  r_off;
    logic [2:0]  r_size;
    logic [31:0] r_wdata;
    logic [3:0]  r_qi;

    logic        r_out_valid;
    logic [31:0] r_rd;
    logic        r_err;
    logic        r_ready;
    logic [3:0]  r_hdr;

    logic        w_fire;
    logic        w_accept;
    logic [31:0] w_rd;
    logic        w_err;
    logic        w_ready;
    logic [3:0]  w_hdr;

    assign w_fire     = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !w_fire;
    assign w_accept   = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_accept || w_fire) begin
            r_in_valid <= w_accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cmd   <= i_cmd;
            r_off   <= i_reg_offset;
            r_size  <= i_access_size;
            r_wdata <= i_write_data;
            r_qi    <= i_queue_index;
        end
    end

    vnet_core #(
        .QUEUE_COUNT  (QUEUE_COUNT),
        .MAX_RING_SIZE(MAX_RING_SIZE)
    ) u_core (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_fire         (w_fire),
        .i_cmd          (r_cmd),
        .i_reg_offset   (r_off),
        .i_access_size  (r_size),
        .i_write_data   (r_wdata),
        .i_queue_index  (r_qi),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .o_read_data    (w_rd),
        .o_access_error (w_err),
        .o_queue_ready  (w_ready),
        .o_header_length(w_hdr)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_fire) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_rd    <= w_rd;
            r_err   <= w_err;
            r_ready <= w_ready;
            r_hdr   <= w_hdr;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_read_data     = r_rd;
    assign o_access_error  = r_err;
    assign o_queue_ready   = r_ready;
    assign o_header_length = r_hdr;

`ifndef NO_ASSERTIONS
    a_fire_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fire |=> o_out_valid)
        else $error("decoded word did not produce a result");

    a_error_reads_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_access_error) |-> (o_read_data == 32'd0))
        else $error("refused access returned nonzero data");

    a_ready_needs_v1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_queue_ready) |-> (o_header_length == HDR_LEN_V1))
        else $error("queue ready without version 1 negotiated");

    a_header_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_header_length == HDR_LEN_V1 || o_header_length == HDR_LEN_LEGACY))
        else $error("header length is neither 10 nor 12");
`endif

endmodule

FILE: sv/vnet_queue.sv
// One virtqueue lane: ring size, enable and the three ring base addresses.
// Depends on vnet_pkg for the offsets and the t_qacc access word.
module vnet_queue #(
    parameter int MAX_RING_SIZE = 256
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  vnet_pkg::t_qacc i_acc,
    input  logic            i_hit,
    output logic [31:0]     o_rd_data,
    output logic            o_ok_next
);
    import vnet_pkg::*;

    localparam int RSW = $clog2(MAX_RING_SIZE + 1);

    logic [RSW-1:0] r_size, n_size;
    logic [15:0]    r_enable, n_enable;
    logic [63:0]    r_desc, n_desc;
    logic [63:0]    r_avail, n_avail;
    logic [63:0]    r_used, n_used;
    logic [15:0]    w_want;

    assign w_want = i_acc.data[15:0];

    always_comb begin
        n_size   = r_size;
        n_enable = r_enable;
        n_desc   = r_desc;
        n_avail  = r_avail;
        n_used   = r_used;
        if (i_acc.clear) begin
            n_size   = RSW'(MAX_RING_SIZE);
            n_enable = '0;
            n_desc   = '0;
            n_avail  = '0;
            n_used   = '0;
        end else if (i_acc.wen && i_hit) begin
            unique case (i_acc.off)
                OFF_Q_SIZE: begin
                    if (w_want > 16'(MAX_RING_SIZE)) begin
                        n_size = RSW'(MAX_RING_SIZE);
                    end else begin
                        n_size = RSW'(w_want);
                    end
                end
                OFF_Q_ENABLE:   n_enable = w_want;
                OFF_Q_DESC_LO:  n_desc[31:0]   = i_acc.data;
                OFF_Q_DESC_HI:  n_desc[63:32]  = i_acc.data;
                OFF_Q_AVAIL_LO: n_avail[31:0]  = i_acc.data;
                OFF_Q_AVAIL_HI: n_avail[63:32] = i_acc.data;
                OFF_Q_USED_LO:  n_used[31:0]   = i_acc.data;
                OFF_Q_USED_HI:  n_used[63:32]  = i_acc.data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size   <= RSW'(MAX_RING_SIZE);
            r_enable <= '0;
            r_desc   <= '0;
            r_avail  <= '0;
            r_used   <= '0;
        end else begin
            r_size   <= n_size;
            r_enable <= n_enable;
            r_desc   <= n_desc;
            r_avail  <= n_avail;
            r_used   <= n_used;
        end
    end

    always_comb begin
        unique case (i_acc.off)
            OFF_Q_SIZE:     o_rd_data = 32'(r_size);
            OFF_Q_ENABLE:   o_rd_data = 32'(r_enable);
            OFF_Q_DESC_LO:  o_rd_data = r_desc[31:0];
            OFF_Q_DESC_HI:  o_rd_data = r_desc[63:32];
            OFF_Q_AVAIL_LO: o_rd_data = r_avail[31:0];
            OFF_Q_AVAIL_HI: o_rd_data = r_avail[63:32];
            OFF_Q_USED_LO:  o_rd_data = r_used[31:0];
            OFF_Q_USED_HI:  o_rd_data = r_used[63:32];
            default:        o_rd_data = '0;
        endcase
    end

    // Readiness is judged on the lane contents after this access.
    assign o_ok_next = (n_enable != '0) && (n_size != '0) && (n_desc != '0)
                    && (n_avail != '0) && (n_used != '0);

endmodule

FILE: sv/vnet_core.sv
// Access decoder and device state: feature windows, status, queue select, ISR,
// configuration registers and the queue lanes. Depends on vnet_pkg, vnet_queue.
module vnet_core #(
    parameter int QUEUE_COUNT   = 2,
    parameter int MAX_RING_SIZE = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_fire,
    input  logic [2:0]  i_cmd,
    input  logic [7:0]  i_reg_offset,
    input  logic [2:0]  i_access_size,
    input  logic [31:0] i_write_data,
    input  logic [3:0]  i_queue_index,
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [47:0] i_cfg_data,
    output logic [31:0] o_read_data,
    output logic        o_access_error,
    output logic        o_queue_ready,
    output logic [3:0]  o_header_length
);
    import vnet_pkg::*;

    logic        r_bme;
    logic [47:0] r_mac;
    logic [31:0] r_dev_win, n_dev_win;
    logic [31:0] r_drv_win, n_drv_win;
    logic [63:0] r_drv_bits, n_drv_bits;
    logic [7:0]  r_status, n_status;
    logic [15:0] r_sel, n_sel;
    logic        r_irq, n_irq;

    logic [QUEUE_COUNT-1:0] w_hit, w_qi_hit, w_ok_next;
    logic [31:0]            w_lane_rd [QUEUE_COUNT];
    logic [31:0]            w_q_rd;
    logic                   w_sel_ok;
    t_qacc                  w_acc;

    logic [31:0] w_rd_val;
    logic [2:0]  w_rd_need;
    logic        w_rd_known;
    logic [2:0]  w_wr_need;
    logic        w_wr_sized;
    logic        w_wr_apply;
    logic        w_clear;
    logic        w_isr_clr, w_irq_set;
    logic [31:0] w_dev_rd;
    logic        w_dev_ok;
    logic [8:0]  w_dev_end;
    logic [47:0] w_mac_sh;
    logic [31:0] w_rd;
    logic        w_err;

    assign w_sel_ok = r_sel < 16'(QUEUE_COUNT);

    // Queue lanes, one per virtqueue.
    for (genvar q = 0; q < QUEUE_COUNT; q++) begin : g_lane
        assign w_hit[q]    = (r_sel == 16'(q));
        assign w_qi_hit[q] = (i_queue_index == 4'(q));
        vnet_queue #(
            .MAX_RING_SIZE(MAX_RING_SIZE)
        ) u_queue (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_acc    (w_acc),
            .i_hit    (w_hit[q]),
            .o_rd_data(w_lane_rd[q]),
            .o_ok_next(w_ok_next[q])
        );
    end

    // A selection past the last queue hits no lane, so it reads zero.
    always_comb begin
        w_q_rd = '0;
        for (int q = 0; q < QUEUE_COUNT; q++) begin
            w_q_rd = w_q_rd | (w_hit[q] ? w_lane_rd[q] : 32'd0);
        end
    end

    // Common-config read decode.
    always_comb begin
        w_rd_known = 1'b1;
        w_rd_need  = 3'd4;
        w_rd_val   = '0;
        unique case (i_reg_offset) inside
            OFF_DEV_FEAT_SEL: w_rd_val = r_dev_win;
            OFF_DEV_FEAT: begin
                if (r_dev_win == 32'd0) begin
                    w_rd_val = DEV_FEAT_WIN0;
                end else if (r_dev_win == 32'd1) begin
                    w_rd_val = DEV_FEAT_WIN1;
                end
            end
            OFF_DRV_FEAT_SEL: w_rd_val = r_drv_win;
            OFF_DRV_FEAT: begin
                if (r_drv_win == 32'd0) begin
                    w_rd_val = r_drv_bits[31:0];
                end else if (r_drv_win == 32'd1) begin
                    w_rd_val = r_drv_bits[63:32];
                end
            end
            OFF_MSIX_CFG, OFF_Q_MSIX: begin
                w_rd_need = 3'd2;
                w_rd_val  = MSIX_UNUSED;
            end
            OFF_NUM_QUEUES: begin
                w_rd_need = 3'd2;
                w_rd_val  = 32'(QUEUE_COUNT);
            end
            OFF_STATUS: begin
                w_rd_need = 3'd1;
                w_rd_val  = 32'(r_status);
            end
            OFF_GENERATION: w_rd_need = 3'd1;
            OFF_Q_SELECT: begin
                w_rd_need = 3'd2;
                w_rd_val  = 32'(r_sel);
            end
            OFF_Q_SIZE, OFF_Q_ENABLE: begin
                w_rd_need = 3'd2;
                w_rd_val  = w_q_rd;
            end
            OFF_Q_NOTIFY: begin
                w_rd_need = 3'd2;
                w_rd_val  = w_sel_ok ? 32'(r_sel) : 32'd0;
            end
            OFF_Q_DESC_LO, OFF_Q_DESC_HI, OFF_Q_AVAIL_LO, OFF_Q_AVAIL_HI,
            OFF_Q_USED_LO, OFF_Q_USED_HI: w_rd_val = w_q_rd;
            default: w_rd_known = 1'b0;
        endcase
    end

    // Common-config write decode: only sized registers check the access size.
    always_comb begin
        w_wr_sized = 1'b1;
        w_wr_need  = 3'd4;
        unique case (i_reg_offset) inside
            OFF_DEV_FEAT_SEL, OFF_DRV_FEAT_SEL, OFF_DRV_FEAT,
            OFF_Q_DESC_LO, OFF_Q_DESC_HI, OFF_Q_AVAIL_LO, OFF_Q_AVAIL_HI,
            OFF_Q_USED_LO, OFF_Q_USED_HI: w_wr_need = 3'd4;
            OFF_Q_SELECT, OFF_Q_SIZE, OFF_Q_ENABLE: w_wr_need = 3'd2;
            OFF_STATUS: w_wr_need = 3'd1;
            default: w_wr_sized = 1'b0;
        endcase
    end

    // Device config: little-endian window onto the station address.
    assign w_dev_end = {1'b0, i_reg_offset} + {6'd0, i_access_size};
    assign w_dev_ok  = ((i_access_size == 3'd1) || (i_access_size == 3'd2)
                        || (i_access_size == 3'd4))
                       && ({1'b0, i_reg_offset} < MAC_BYTES) && (w_dev_end <= MAC_BYTES);
    assign w_mac_sh  = r_mac >> {i_reg_offset[2:0], 3'b000};

    always_comb begin
        case (i_access_size)
            3'd1:    w_dev_rd = {24'd0, w_mac_sh[7:0]};
            3'd2:    w_dev_rd = {16'd0, w_mac_sh[15:0]};
            default: w_dev_rd = w_mac_sh[31:0];
        endcase
    end

    always_comb begin
        w_err      = 1'b0;
        w_rd       = '0;
        w_wr_apply = 1'b0;
        w_isr_clr  = 1'b0;
        w_irq_set  = 1'b0;
        unique case (i_cmd)
            CMD_COMMON_READ: begin
                if (i_reg_offset >= CFG_REGION_BYTES || !w_rd_known
                    || i_access_size != w_rd_need) begin
                    w_err = 1'b1;
                end else begin
                    w_rd = w_rd_val;
                end
            end
            CMD_COMMON_WRITE: begin
                if (i_reg_offset >= CFG_REGION_BYTES) begin
                    w_err = 1'b1;
                end else if (w_wr_sized && i_access_size != w_wr_need) begin
                    w_err = 1'b1;
                end else begin
                    w_wr_apply = w_wr_sized;
                end
            end
            CMD_DEVICE_READ: begin
                if (w_dev_ok) begin
                    w_rd = w_dev_rd;
                end else begin
                    w_err = 1'b1;
                end
            end
            CMD_ISR_READ: begin
                w_rd      = {31'd0, r_irq};
                w_isr_clr = 1'b1;
            end
            CMD_RAISE_IRQ: w_irq_set = 1'b1;
            default: w_err = 1'b1;
        endcase
    end

    assign w_clear = i_fire && w_wr_apply && (i_reg_offset == OFF_STATUS)
                  && (i_write_data[7:0] == 8'd0);

    assign w_acc.wen   = i_fire && w_wr_apply && w_sel_ok;
    assign w_acc.clear = w_clear;
    assign w_acc.off   = i_reg_offset;
    assign w_acc.data  = i_write_data;

    always_comb begin
        n_dev_win  = r_dev_win;
        n_drv_win  = r_drv_win;
        n_drv_bits = r_drv_bits;
        n_status   = r_status;
        n_sel      = r_sel;
        n_irq      = r_irq;
        if (w_clear) begin
            n_dev_win  = '0;
            n_drv_win  = '0;
            n_drv_bits = '0;
            n_status   = '0;
            n_sel      = '0;
            n_irq      = 1'b0;
        end else if (i_fire) begin
            if (w_isr_clr) begin
                n_irq = 1'b0;
            end
            if (w_irq_set) begin
                n_irq = 1'b1;
            end
            if (w_wr_apply) begin
                unique case (i_reg_offset)
                    OFF_DEV_FEAT_SEL: n_dev_win = i_write_data;
                    OFF_DRV_FEAT_SEL: n_drv_win = i_write_data;
                    OFF_DRV_FEAT: begin
                        if (r_drv_win == 32'd0) begin
                            n_drv_bits[31:0] = i_write_data;
                        end else if (r_drv_win == 32'd1) begin
                            n_drv_bits[63:32] = i_write_data;
                        end
                    end
                    OFF_STATUS:   n_status = i_write_data[7:0];
                    OFF_Q_SELECT: n_sel = i_write_data[15:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dev_win  <= '0;
            r_drv_win  <= '0;
            r_drv_bits <= '0;
            r_status   <= '0;
            r_sel      <= '0;
            r_irq      <= 1'b0;
        end else begin
            r_dev_win  <= n_dev_win;
            r_drv_win  <= n_drv_win;
            r_drv_bits <= n_drv_bits;
            r_status   <= n_status;
            r_sel      <= n_sel;
            r_irq      <= n_irq;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bme <= 1'b1;
            r_mac <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_DMA_ENABLE: r_bme <= i_cfg_data[0];
                CFG_MAC:        r_mac <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Ready and header length reflect the state this access leaves behind.
    assign o_read_data     = w_rd;
    assign o_access_error  = w_err;
    assign o_queue_ready   = n_status[STATUS_DRIVER_OK_BIT] && n_drv_bits[FEAT_VERSION_1]
                          && r_bme && ((w_ok_next & w_qi_hit) != '0);
    assign o_header_length = n_drv_bits[FEAT_VERSION_1] ? HDR_LEN_V1 : HDR_LEN_LEGACY;

endmodule
